// ===== rtl/core/tcvs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcvs_pkg: shared definitions for the two-hand clock victim selector
// Opcodes, status codes, register indexes, widths and the request and response
// types of the iterative remainder unit.
// ----------------------------------------------------------------------------
package tcvs_pkg;

  localparam int FRAME_COUNT_DEFAULT = 64;

  // width of frames_in_use and of every value the remainder unit handles
  localparam int VAL_W     = 7;
  localparam int GAP_W     = 6;
  localparam int FRAME_W   = 6;
  localparam int STEP_W    = $clog2(VAL_W);
  localparam int CFG_IDX_W = 2;

  localparam int FIU_RESET = 64;
  localparam int GAP_RESET = 16;

  localparam logic [1:0] OP_TOUCH = 2'd0;
  localparam logic [1:0] OP_PIN   = 2'd1;
  localparam logic [1:0] OP_UNPIN = 2'd2;
  localparam logic [1:0] OP_EVICT = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_VICTIM = 2'd1;
  localparam logic [1:0] STAT_NONE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HAND_GAP      = 2'd1;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } tcvs_rem_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] rem;
  } tcvs_rem_rsp_t;

endpackage

// ===== rtl/core/tcvs_rem.sv =====
// ----------------------------------------------------------------------------
// tcvs_rem: iterative remainder unit
// Restoring shift-subtract remainder, one dividend bit per cycle through a
// single compare and subtract. Done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module tcvs_rem
  import tcvs_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  tcvs_rem_req_t req,
  output tcvs_rem_rsp_t rsp
);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VAL_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [VAL_W-1:0]  dvd_r, dvd_nxt;
  logic [VAL_W-1:0]  dsr_r, dsr_nxt;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    diff;

  always_comb begin
    trial = {rem_r, dvd_r[VAL_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      diff = trial - {1'b0, dsr_r};
    end else begin
      diff = trial;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = diff[VAL_W-1:0];
      dvd_nxt = {dvd_r[VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/core/two_hand_clock_victim_select.sv =====
// ----------------------------------------------------------------------------
// two_hand_clock_victim_select: two-handed clock victim selection
// Touch, pin and unpin requests update per-frame bit memories; an eviction
// request walks both hands one frame per step until a victim is found.
// Touch, pin, unpin: the result is registered, shown in the cycle after the
//   request is taken; a new one waits only on a stalled result or cfg_valid.
// Eviction: each frame step is a registered memory read, then a test, for up to
//   2 x frames_in_use steps (frames_in_use held to 1..FRAME_COUNT); a hand at or
//   beyond it is first reduced by the shared remainder unit. Writing hand_gap
//   sets the clear hand to hand_gap, reduced the same way.
// Reset clears both bit memories in a pass over every frame; requests wait for
//   it, configuration writes are taken meanwhile unless a hand_gap write waits.
// ----------------------------------------------------------------------------
module two_hand_clock_victim_select
  import tcvs_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // frame_index[5:0]
  input  logic [1:0]           in_tuser,   // opcode[1:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // victim_index[5:0]
  output logic [1:0]           out_tuser,  // status[1:0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  localparam int HW          = $clog2(FRAME_COUNT);
  localparam int CW          = (HW + 1 > VAL_W) ? HW + 1 : VAL_W;
  localparam int RESET_LIVE  = (FRAME_COUNT < FIU_RESET) ? FRAME_COUNT : FIU_RESET;
  localparam int RESET_CLEAR = GAP_RESET % RESET_LIVE;
  localparam int NFRAMES_IN  = 1 << FRAME_W;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHK_G  = 4'd2;
  localparam logic [3:0] S_WAIT_G = 4'd3;
  localparam logic [3:0] S_CHK_E  = 4'd4;
  localparam logic [3:0] S_WAIT_E = 4'd5;
  localparam logic [3:0] S_CHK_C  = 4'd6;
  localparam logic [3:0] S_WAIT_C = 4'd7;
  localparam logic [3:0] S_RD     = 4'd8;
  localparam logic [3:0] S_EVAL   = 4'd9;
  localparam logic [3:0] S_PUSH   = 4'd10;

  logic [3:0]         state_r, state_nxt;
  logic [VAL_W-1:0]   fiu_r, fiu_nxt;
  logic [GAP_W-1:0]   gap_r, gap_nxt;
  logic [HW-1:0]      evict_r, evict_nxt;
  logic [HW-1:0]      clear_r, clear_nxt;
  logic [HW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               gap_pend_r, gap_pend_nxt;
  logic [VAL_W:0]     steps_r, steps_nxt;
  logic               fwd_r, fwd_nxt;
  logic [HW-1:0]      ef_r, ef_nxt;
  logic [1:0]         pend_status_r, pend_status_nxt;
  logic [FRAME_W-1:0] pend_victim_r, pend_victim_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [FRAME_W-1:0] out_victim_r, out_victim_nxt;

  logic               acc_mem [FRAME_COUNT];
  logic               pin_mem [FRAME_COUNT];
  logic               acc_rd_r, pin_rd_r;
  logic               acc_we, acc_wd, pin_we, pin_wd;
  logic [HW-1:0]      acc_waddr, pin_waddr;

  logic [HW-1:0]      wrap_lut [NFRAMES_IN];
  logic [HW-1:0]      frame_w;
  logic [VAL_W-1:0]   live_n;
  logic               evict_lt, clear_lt, gap_lt;
  logic [HW-1:0]      e_adv, c_adv;
  logic               in_fire, cfg_fire, gap_fire;

  tcvs_rem_req_t      rem_req;
  tcvs_rem_rsp_t      rem_rsp;

  tcvs_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // frame index reduced modulo the frame count
  for (genvar g = 0; g < NFRAMES_IN; g++) begin : g_wrap
    assign wrap_lut[g] = HW'(g % FRAME_COUNT);
  end
  assign frame_w = wrap_lut[in_tdata[FRAME_W-1:0]];

  always_comb begin
    if (fiu_r == '0) begin
      live_n = VAL_W'(1);
    end else if (CW'(fiu_r) > CW'(FRAME_COUNT)) begin
      live_n = VAL_W'(FRAME_COUNT);
    end else begin
      live_n = fiu_r;
    end
  end

  assign evict_lt = CW'(evict_r) < CW'(live_n);
  assign clear_lt = CW'(clear_r) < CW'(live_n);
  assign gap_lt   = CW'(gap_r) < CW'(live_n);
  assign e_adv    = (CW'(evict_r) + CW'(1) == CW'(live_n)) ? '0 : evict_r + HW'(1);
  assign c_adv    = (CW'(clear_r) + CW'(1) == CW'(live_n)) ? '0 : clear_r + HW'(1);

  assign cfg_ready = (state_r == S_IDLE) || ((state_r == S_CLR) && !gap_pend_r);
  assign in_tready = (state_r == S_IDLE) && !cfg_valid && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign gap_fire  = cfg_fire && (cfg_index == REG_HAND_GAP);

  always_comb begin
    state_nxt       = state_r;
    fiu_nxt         = fiu_r;
    gap_nxt         = gap_r;
    evict_nxt       = evict_r;
    clear_nxt       = clear_r;
    clr_addr_nxt    = clr_addr_r;
    gap_pend_nxt    = gap_pend_r;
    steps_nxt       = steps_r;
    fwd_nxt         = fwd_r;
    ef_nxt          = ef_r;
    pend_status_nxt = pend_status_r;
    pend_victim_nxt = pend_victim_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_victim_nxt  = out_victim_r;
    acc_we          = 1'b0;
    acc_waddr       = clear_r;
    acc_wd          = 1'b0;
    pin_we          = 1'b0;
    pin_waddr       = ef_r;
    pin_wd          = 1'b1;
    rem_req.start    = 1'b0;
    rem_req.dividend = '0;
    rem_req.divisor  = live_n;

    if (cfg_fire) begin
      unique case (cfg_index)
        REG_FRAMES_IN_USE: begin
          fiu_nxt = cfg_data;
        end
        REG_HAND_GAP: begin
          gap_nxt   = cfg_data[GAP_W-1:0];
          evict_nxt = '0;
          if (state_r == S_CLR) begin
            gap_pend_nxt = 1'b1;
          end else begin
            state_nxt = S_CHK_G;
          end
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_CLR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr_r;
        acc_wd    = 1'b0;
        pin_we    = 1'b1;
        pin_waddr = clr_addr_r;
        pin_wd    = 1'b0;
        if (clr_addr_r == HW'(FRAME_COUNT - 1)) begin
          state_nxt = (gap_pend_r || gap_fire) ? S_CHK_G : S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + HW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_tuser)
            OP_TOUCH: begin
              acc_we    = 1'b1;
              acc_waddr = frame_w;
              acc_wd    = 1'b1;
            end
            OP_PIN: begin
              pin_we    = 1'b1;
              pin_waddr = frame_w;
              pin_wd    = 1'b1;
            end
            OP_UNPIN: begin
              pin_we    = 1'b1;
              pin_waddr = frame_w;
              pin_wd    = 1'b0;
            end
            OP_EVICT: begin
              steps_nxt = '0;
              state_nxt = S_CHK_E;
            end
            default: begin
            end
          endcase
          if (in_tuser != OP_EVICT) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_OK;
            out_victim_nxt = '0;
          end
        end
      end
      S_CHK_G: begin
        gap_pend_nxt = 1'b0;
        if (gap_lt) begin
          clear_nxt = HW'(gap_r);
          state_nxt = S_IDLE;
        end else begin
          rem_req.start    = 1'b1;
          rem_req.dividend = VAL_W'(gap_r);
          state_nxt        = S_WAIT_G;
        end
      end
      S_WAIT_G: begin
        if (rem_rsp.done) begin
          clear_nxt = HW'(rem_rsp.rem);
          state_nxt = S_IDLE;
        end
      end
      S_CHK_E: begin
        if (evict_lt) begin
          state_nxt = S_CHK_C;
        end else begin
          rem_req.start    = 1'b1;
          rem_req.dividend = VAL_W'(evict_r);
          state_nxt        = S_WAIT_E;
        end
      end
      S_WAIT_E: begin
        if (rem_rsp.done) begin
          evict_nxt = HW'(rem_rsp.rem);
          state_nxt = S_CHK_C;
        end
      end
      S_CHK_C: begin
        if (clear_lt) begin
          state_nxt = S_RD;
        end else begin
          rem_req.start    = 1'b1;
          rem_req.dividend = VAL_W'(clear_r);
          state_nxt        = S_WAIT_C;
        end
      end
      S_WAIT_C: begin
        if (rem_rsp.done) begin
          clear_nxt = HW'(rem_rsp.rem);
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // clear hand acts first; a clear on the evict frame is forwarded
        acc_we    = 1'b1;
        acc_waddr = clear_r;
        acc_wd    = 1'b0;
        fwd_nxt   = (clear_r == evict_r);
        ef_nxt    = evict_r;
        evict_nxt = e_adv;
        clear_nxt = c_adv;
        steps_nxt = steps_r + (VAL_W + 1)'(1);
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!pin_rd_r && !(acc_rd_r && !fwd_r)) begin
          pin_we          = 1'b1;
          pin_waddr       = ef_r;
          pin_wd          = 1'b1;
          pend_status_nxt = STAT_VICTIM;
          pend_victim_nxt = FRAME_W'(ef_r);
          state_nxt       = S_PUSH;
        end else if (steps_r == {live_n, 1'b0}) begin
          pend_status_nxt = STAT_NONE;
          pend_victim_nxt = '0;
          state_nxt       = S_PUSH;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_victim_nxt = pend_victim_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      fiu_r       <= VAL_W'(FIU_RESET);
      gap_r       <= GAP_W'(GAP_RESET);
      evict_r     <= '0;
      clear_r     <= HW'(RESET_CLEAR);
      clr_addr_r  <= '0;
      gap_pend_r  <= 1'b0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fiu_r       <= fiu_nxt;
      gap_r       <= gap_nxt;
      evict_r     <= evict_nxt;
      clear_r     <= clear_nxt;
      clr_addr_r  <= clr_addr_nxt;
      gap_pend_r  <= gap_pend_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r         <= fwd_nxt;
    ef_r          <= ef_nxt;
    pend_status_r <= pend_status_nxt;
    pend_victim_r <= pend_victim_nxt;
    out_status_r  <= out_status_nxt;
    out_victim_r  <= out_victim_nxt;
  end

  // bit memories, read at the evict hand
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wd;
    end
    acc_rd_r <= acc_mem[evict_r];
  end

  always_ff @(posedge clk) begin
    if (pin_we) begin
      pin_mem[pin_waddr] <= pin_wd;
    end
    pin_rd_r <= pin_mem[evict_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_victim_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== rtl/core/tcvs_checker.sv =====
// ----------------------------------------------------------------------------
// tcvs_checker: port-level checks for the victim selector
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module tcvs_checker
  import tcvs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_VICTIM |-> out_tdata == 8'd0)
    else $error("victim index not zero without a victim");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == STAT_OK || out_tuser == STAT_VICTIM || out_tuser == STAT_NONE)
    else $error("bad status code");

  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("busy sweep not entered after reset");

  a_event_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != OP_EVICT |=> out_tvalid && out_tuser == STAT_OK)
    else $error("event request gave no immediate result");

endmodule

bind two_hand_clock_victim_select tcvs_checker u_tcvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== verif/tb_two_hand_clock_victim_select.sv =====
// ----------------------------------------------------------------------------
// tb_two_hand_clock_victim_select: self-checking bench for the victim selector
// Drives touch, pin, unpin and eviction requests with random gaps against a
// randomly stalling result port, rewrites the frame count and hand gap between
// phases, and compares every result with a bit-accurate model of the clock.
// ----------------------------------------------------------------------------
module tb_two_hand_clock_victim_select;
  import tcvs_pkg::*;

  localparam int FRAMES       = FRAME_COUNT_DEFAULT;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 140;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 2000000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] victim;
  } clock_result_t;

  class victim_tracker;
    bit             accessed_map [FRAMES];
    bit             pinned_map   [FRAMES];
    int unsigned    evict_pos;
    int unsigned    clear_pos;
    bit [VAL_W-1:0] frames_in_use;
    bit [GAP_W-1:0] hand_gap;
    clock_result_t  pending_results [$];
    int             fail_count;
    int             checked_count;

    function new();
      foreach (accessed_map[i]) begin
        accessed_map[i] = 1'b0;
        pinned_map[i]   = 1'b0;
      end
      frames_in_use = VAL_W'(FIU_RESET);
      hand_gap      = GAP_W'(GAP_RESET);
      evict_pos     = 0;
      clear_pos     = GAP_RESET % FIU_RESET;
      fail_count    = 0;
      checked_count = 0;
    endfunction

    function int unsigned live_count();
      int unsigned n;
      n = frames_in_use;
      if (n == 0) n = 1;
      if (n > FRAMES) n = FRAMES;
      return n;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
      if (idx == REG_FRAMES_IN_USE) begin
        frames_in_use = data;
      end else if (idx == REG_HAND_GAP) begin
        hand_gap  = data[GAP_W-1:0];
        evict_pos = 0;
        clear_pos = hand_gap % live_count();
      end
    endfunction

    function void note_request(logic [1:0] op, logic [FRAME_W-1:0] frame);
      clock_result_t res;
      int unsigned   n, e, c, ef, cf, steps;
      res.status = STAT_OK;
      res.victim = '0;
      case (op)
        OP_TOUCH: accessed_map[frame] = 1'b1;
        OP_PIN:   pinned_map[frame]   = 1'b1;
        OP_UNPIN: pinned_map[frame]   = 1'b0;
        default: begin
          n = live_count();
          e = evict_pos % n;
          c = clear_pos % n;
          res.status = STAT_NONE;
          for (steps = 0; steps < 2 * n; steps++) begin
            ef = e;
            cf = c;
            e = (e + 1 == n) ? 0 : e + 1;
            c = (c + 1 == n) ? 0 : c + 1;
            accessed_map[cf] = 1'b0;
            if (!pinned_map[ef] && !accessed_map[ef]) begin
              pinned_map[ef] = 1'b1;
              res.status = STAT_VICTIM;
              res.victim = FRAME_W'(ef);
              break;
            end
          end
          evict_pos = e;
          clear_pos = c;
        end
      endcase
      pending_results.push_back(res);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      fail_count++;
    endtask

    task check_result(logic [1:0] status, logic [FRAME_W-1:0] victim);
      clock_result_t exp_res;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d victim %0d",
                         status, victim));
      end else begin
        exp_res = pending_results.pop_front();
        if (status !== exp_res.status)
          report($sformatf("result %0d status %0d, expected %0d",
                           checked_count, status, exp_res.status));
        if (victim !== exp_res.victim)
          report($sformatf("result %0d victim %0d, expected %0d",
                           checked_count, victim, exp_res.victim));
      end
      checked_count++;
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // frame_index[5:0]
  logic [1:0]           in_tuser;   // opcode[1:0]
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // victim_index[5:0]
  logic [1:0]           out_tuser;  // status[1:0]
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_data;

  victim_tracker tracker;
  int            cycle_count    = 0;
  int            burst_left     = 0;
  int            request_count  = 0;
  int            evict_count    = 0;
  int            victim_count   = 0;
  int            none_count     = 0;
  int            settings_count = 0;

  two_hand_clock_victim_select #(
    .FRAME_COUNT(FRAMES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = 40;
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  task automatic send_request(logic [1:0] op, logic [FRAME_W-1:0] frame, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, frame};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(op, frame);
    request_count++;
    if (op == OP_EVICT) evict_count++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic push_register(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(idx, data);
  endtask

  // order 0: count then gap, 1: gap then count, 2: count only, 3: gap only
  task automatic apply_settings(logic [VAL_W-1:0] fiu_val, logic [VAL_W-1:0] gap_val,
                                int order, bit spare_write);
    wait_idle();
    case (order)
      0: begin
        push_register(REG_FRAMES_IN_USE, fiu_val);
        push_register(REG_HAND_GAP, gap_val);
      end
      1: begin
        push_register(REG_HAND_GAP, gap_val);
        push_register(REG_FRAMES_IN_USE, fiu_val);
      end
      2: push_register(REG_FRAMES_IN_USE, fiu_val);
      default: push_register(REG_HAND_GAP, gap_val);
    endcase
    if (spare_write)
      push_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, VAL_W'($urandom));
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  initial begin
    int r;
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r >= 45) begin
        out_tready <= 1'b0;
        repeat ((r < 88) ? $urandom_range(1, 3) : $urandom_range(5, 25)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tuser, out_tdata[FRAME_W-1:0]);
      if (out_tuser == STAT_VICTIM) victim_count++;
      if (out_tuser == STAT_NONE) none_count++;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int               p, k, f, r;
    int unsigned      live;
    logic [1:0]       op;
    logic [FRAME_W-1:0] frame;
    logic [VAL_W-1:0] fiu_val, gap_val;

    tracker = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_TOUCH;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FRAMES_IN_USE;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full frame range, gap of sixteen
    send_request(OP_TOUCH, 6'd0, 0);
    send_request(OP_TOUCH, 6'd63, 0);
    send_request(OP_PIN, 6'd5, 1);
    send_request(OP_UNPIN, 6'd5, 0);
    send_request(OP_PIN, 6'd0, 0);
    send_request(OP_EVICT, 6'd63, 0);
    send_request(OP_EVICT, 6'd0, 2);

    // four frames all pinned, then a frame freed only after the clear hand passes
    apply_settings(7'd4, 7'd1, 0, 1'b0);
    for (f = 0; f < 4; f++) send_request(OP_PIN, FRAME_W'(f), 0);
    send_request(OP_EVICT, 6'd0, 0);
    send_request(OP_UNPIN, 6'd2, 0);
    send_request(OP_TOUCH, 6'd2, 0);
    send_request(OP_EVICT, 6'd17, 0);
    send_request(OP_TOUCH, 6'd45, 0);
    send_request(OP_UNPIN, 6'd45, 0);

    // zero frame count with hands kept
    apply_settings(7'd0, 7'd0, 2, 1'b0);
    send_request(OP_UNPIN, 6'd0, 0);
    send_request(OP_EVICT, 6'd0, 0);
    send_request(OP_EVICT, 6'd0, 0);

    // oversized count, gap with its unused top bit set, writes to spare indexes
    apply_settings(7'd127, 7'd127, 1, 1'b1);
    send_request(OP_TOUCH, 6'd63, 0);
    send_request(OP_EVICT, 6'd0, 0);
    send_request(OP_EVICT, 6'd0, 0);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin fiu_val = 7'd64;  gap_val = 7'd16;  end
        1: begin fiu_val = 7'd1;   gap_val = 7'd0;   end
        2: begin fiu_val = 7'd2;   gap_val = 7'd63;  end
        3: begin fiu_val = 7'd0;   gap_val = 7'd7;   end
        4: begin fiu_val = 7'd127; gap_val = 7'd40;  end
        5: begin fiu_val = 7'd5;   gap_val = 7'd127; end
        default: begin
          fiu_val = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom) :
                                                   VAL_W'($urandom_range(1, 64));
          gap_val = VAL_W'($urandom);
        end
      endcase
      apply_settings(fiu_val, gap_val, (p == 0) ? 0 : $urandom_range(0, 3),
                     $urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        live = tracker.live_count();
        if (live <= 8 && $urandom_range(0, 49) == 0) begin
          for (f = 0; f < live; f++) send_request(OP_PIN, FRAME_W'(f), next_gap());
          send_request(OP_EVICT, FRAME_W'($urandom), next_gap());
        end
        r = $urandom_range(0, 99);
        op = (r < 35) ? OP_TOUCH : (r < 50) ? OP_PIN : (r < 80) ? OP_UNPIN : OP_EVICT;
        frame = ($urandom_range(0, 9) < 7) ? FRAME_W'($urandom_range(0, live - 1)) :
                                             FRAME_W'($urandom);
        send_request(op, frame, next_gap());
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests over %0d register settings", request_count,
             settings_count);
    $display("%0d evictions: %0d victims chosen, %0d with no free frame", evict_count,
             victim_count, none_count);
    if (tracker.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
